// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset
`define QRS_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("qrs assertion failed");

// Next-cycle implication, disabled in reset
`define QRS_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("qrs assertion failed");

`endif

// ===== hw/rtl/qrs_pkg.sv =====
// Types, widths and helpers for the quadratic root solver
package qrs_pkg;

  localparam int CW    = 32;  // coefficient and root width
  localparam int EPS_W = 16;  // epsilon register width
  localparam int DW    = 66;  // discriminant width
  localparam int SW    = 33;  // square root width
  localparam int SN    = 33;  // square root digit stages
  localparam int RW    = 37;  // square root remainder width
  localparam int MW    = 34;  // numerator magnitude width
  localparam int QW    = 33;  // denominator width
  localparam int QRW   = 34;  // divider remainder width
  localparam int QB    = 32;  // quotient bits, one per stage

  localparam logic signed [CW-1:0] ROOT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CW-1:0] ROOT_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {MODE_NONE, MODE_LIN, MODE_DBL, MODE_TWO} mode_t;

  typedef struct packed {
    logic signed [CW-1:0] coef_a;
    logic signed [CW-1:0] coef_b;
    logic signed [CW-1:0] coef_c;
  } in_item_t;

  typedef struct packed {
    logic                 has_solution;
    logic signed [CW-1:0] root_first;
    logic signed [CW-1:0] root_second;
    logic                 overflow;
  } out_item_t;

  // sideband carried alongside the discriminant and its root
  typedef struct packed {
    mode_t                mode;
    logic                 a_neg;
    logic [CW-1:0]        a_mag;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } meta_t;

  typedef struct packed {
    logic [MW-1:0] mag;
    logic          neg;
  } plane_t;

  typedef struct packed {
    plane_t [1:0]  ln;
    logic [QW-1:0] den;
    logic          den_neg;
    logic          ok;
  } prep_t;

  typedef struct packed {
    logic [QRW-1:0] rem;
    logic [QB-1:0]  lo;
    logic [QB-1:0]  q;
    logic           big;
    logic           sgn;
  } dlane_t;

  typedef struct packed {
    dlane_t [1:0]  ln;
    logic [QW-1:0] den;
    logic          ok;
  } dstage_t;

  // magnitude of a two's complement word (most negative maps to 2^31)
  function automatic logic [CW-1:0] mag32(input logic [CW-1:0] v);
    return v[CW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

// ===== hw/rtl/qrs_front.sv =====
// Front end: magnitudes, products, discriminant and case selection
module qrs_front #(
  parameter int FRAC_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [qrs_pkg::EPS_W-1:0] epsilon,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  qrs_pkg::in_item_t       in_item,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [qrs_pkg::DW-1:0]  out_d,
  output qrs_pkg::meta_t          out_meta
);
  import qrs_pkg::*;

  localparam int TW = EPS_W + FRAC_BITS;

  logic va_r, vb_r, vc_r, vd_r;
  logic rdy_a, rdy_b, rdy_c, rdy_d;
  in_item_t ia_r;
  logic [2*CW-1:0] b2_r, p_r, b2_nxt, p_nxt;
  logic nza_r, nzb_r, sdiff_r, nza_c_r, nzb_c_r, negd_r;
  logic nza_nxt, nzb_nxt;
  meta_t mb_r, mc_r, md_r, mb_nxt, md_nxt;
  logic [DW-1:0] dc_r, dd_r, dc_nxt;
  logic negd_nxt;
  logic [CW-1:0] am, bm, cm;
  logic [DW-1:0] b2x, p4, thr;

  // stall chain
  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign rdy_b    = !vb_r || rdy_c;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // stage B: magnitudes and the two products
  always_comb begin
    am = mag32(ia_r.coef_a);
    bm = mag32(ia_r.coef_b);
    cm = mag32(ia_r.coef_c);
    b2_nxt  = 64'(bm) * 64'(bm);
    p_nxt   = 64'(am) * 64'(cm);
    nza_nxt = (am == '0) || (am < {{(CW-EPS_W){1'b0}}, epsilon});
    nzb_nxt = (bm == '0) || (bm < {{(CW-EPS_W){1'b0}}, epsilon});
    mb_nxt       = '0;
    mb_nxt.mode  = MODE_NONE;
    mb_nxt.a_neg = ia_r.coef_a[CW-1];
    mb_nxt.a_mag = am;
    mb_nxt.b     = ia_r.coef_b;
    mb_nxt.c     = ia_r.coef_c;
  end

  // stage C: d = b^2 - 4ac, exact; a negative d is flagged and zeroed
  always_comb begin
    b2x = {2'b00, b2_r};
    p4  = {p_r, 2'b00};
    negd_nxt = 1'b0;
    if (sdiff_r) begin
      dc_nxt = b2x + p4;
    end else if (b2x < p4) begin
      dc_nxt   = '0;
      negd_nxt = 1'b1;
    end else begin
      dc_nxt = b2x - p4;
    end
  end

  // stage D: pick linear, none, double or two roots
  always_comb begin
    thr = {{(DW-TW){1'b0}}, epsilon, {FRAC_BITS{1'b0}}};
    md_nxt = mc_r;
    if (nza_c_r) begin
      md_nxt.mode = nzb_c_r ? MODE_NONE : MODE_LIN;
    end else if (negd_r) begin
      md_nxt.mode = MODE_NONE;
    end else if (dc_r < thr) begin
      md_nxt.mode = MODE_DBL;
    end else begin
      md_nxt.mode = MODE_TWO;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
      if (rdy_c) vc_r <= vb_r;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a) ia_r <= in_item;
    if (rdy_b) begin
      b2_r    <= b2_nxt;
      p_r     <= p_nxt;
      nza_r   <= nza_nxt;
      nzb_r   <= nzb_nxt;
      sdiff_r <= ia_r.coef_a[CW-1] != ia_r.coef_c[CW-1];
      mb_r    <= mb_nxt;
    end
    if (rdy_c) begin
      dc_r    <= dc_nxt;
      negd_r  <= negd_nxt;
      nza_c_r <= nza_r;
      nzb_c_r <= nzb_r;
      mc_r    <= mb_r;
    end
    if (rdy_d) begin
      dd_r <= dc_r;
      md_r <= md_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_d     = dd_r;
  assign out_meta  = md_r;

endmodule

// ===== hw/rtl/qrs_sqrt.sv =====
// Pipelined floor square root, one root bit per stage
module qrs_sqrt (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [qrs_pkg::DW-1:0] in_d,
  input  qrs_pkg::meta_t         in_meta,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [qrs_pkg::SW-1:0] out_root,
  output qrs_pkg::meta_t         out_meta
);
  import qrs_pkg::*;

  logic          v_r    [SN];
  logic [RW-1:0] rem_r  [SN];
  logic [SW-1:0] root_r [SN];
  logic [DW-1:0] d_r    [SN];
  meta_t         m_r    [SN];
  logic          rdy    [SN+1];

  assign rdy[SN]   = out_ready;
  assign in_ready  = rdy[0];

  for (genvar k = 0; k < SN; k++) begin : g_stage
    logic          v_p;
    logic [RW-1:0] rem_p, cur, trial, rem_nxt;
    logic [SW-1:0] root_p, root_nxt;
    logic [DW-1:0] d_p;
    meta_t         m_p;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_p    = in_valid;
      assign rem_p  = '0;
      assign root_p = '0;
      assign d_p    = in_d;
      assign m_p    = in_meta;
    end else begin : g_next
      assign v_p    = v_r[k-1];
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign d_p    = d_r[k-1];
      assign m_p    = m_r[k-1];
    end

    assign rdy[k] = !v_r[k] || rdy[k+1];

    // bring down the next pair of bits and try a one digit
    always_comb begin
      cur      = {rem_p[RW-3:0], d_p[2*(SN-1-k) +: 2]};
      trial    = {{(RW-SW-2){1'b0}}, root_p, 2'b01};
      ge       = cur >= trial;
      rem_nxt  = ge ? (cur - trial) : cur;
      root_nxt = {root_p[SW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (rdy[k]) begin
        v_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[k]) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        d_r[k]    <= d_p;
        m_r[k]    <= m_p;
      end
    end
  end

  assign out_valid = v_r[SN-1];
  assign out_root  = root_r[SN-1];
  assign out_meta  = m_r[SN-1];

endmodule

// ===== hw/rtl/qrs_div.sv =====
// Numerator set-up, two-lane pipelined divider and saturation
module qrs_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [qrs_pkg::SW-1:0] in_root,
  input  qrs_pkg::meta_t         in_meta,
  output logic                   out_valid,
  input  logic                   out_ready,
  output qrs_pkg::out_item_t     out_item
);
  import qrs_pkg::*;

  localparam int NW = MW + FRAC_BITS;
  localparam int HW = NW - QB;

  logic      vp_r, ve_r, vf_r;
  logic      rdy_p, rdy_e, rdy_f;
  prep_t     p_r, p_nxt;
  dstage_t   e_r, e_nxt;
  out_item_t f_r, f_nxt;
  logic      vk_r [QB];
  dstage_t   k_r  [QB];
  logic      rdk  [QB+1];

  logic signed [CW+3:0] bx, sx, n0, n1;
  logic [CW+3:0]        n0m, n1m;

  // stall chain
  assign rdy_f    = !vf_r || out_ready;
  assign rdk[QB]  = rdy_f;
  assign rdy_e    = !ve_r || rdk[0];
  assign rdy_p    = !vp_r || rdy_e;
  assign in_ready = rdy_p;

  // set up numerators and denominator for the chosen case
  always_comb begin
    bx  = {{4{in_meta.b[CW-1]}}, in_meta.b};
    sx  = {3'b000, in_root};
    n0  = -bx - sx;
    n1  = sx - bx;
    n0m = n0[CW+3] ? (~n0 + 1'b1) : n0;
    n1m = n1[CW+3] ? (~n1 + 1'b1) : n1;
    p_nxt = '0;
    unique case (in_meta.mode)
      MODE_LIN: begin
        p_nxt.ok        = 1'b1;
        p_nxt.ln[0].mag = {2'b00, mag32(in_meta.c)};
        p_nxt.ln[0].neg = !in_meta.c[CW-1] && (in_meta.c != '0);
        p_nxt.ln[1]     = p_nxt.ln[0];
        p_nxt.den       = {1'b0, mag32(in_meta.b)};
        p_nxt.den_neg   = in_meta.b[CW-1];
      end
      MODE_DBL: begin
        p_nxt.ok        = 1'b1;
        p_nxt.ln[0].mag = {2'b00, mag32(in_meta.b)};
        p_nxt.ln[0].neg = !in_meta.b[CW-1] && (in_meta.b != '0);
        p_nxt.ln[1]     = p_nxt.ln[0];
        p_nxt.den       = {in_meta.a_mag, 1'b0};
        p_nxt.den_neg   = in_meta.a_neg;
      end
      MODE_TWO: begin
        p_nxt.ok        = 1'b1;
        p_nxt.ln[0].mag = n0m[MW-1:0];
        p_nxt.ln[0].neg = n0[CW+3];
        p_nxt.ln[1].mag = n1m[MW-1:0];
        p_nxt.ln[1].neg = n1[CW+3];
        p_nxt.den       = {in_meta.a_mag, 1'b0};
        p_nxt.den_neg   = in_meta.a_neg;
      end
      default: begin
        p_nxt.ok = 1'b0;
      end
    endcase
  end

  // scale numerator, flag quotients of 2^32 and above, seed remainder
  always_comb begin
    logic [NW-1:0] nw;
    e_nxt     = '0;
    e_nxt.den = p_r.den;
    e_nxt.ok  = p_r.ok;
    for (int i = 0; i < 2; i++) begin
      nw = {p_r.ln[i].mag, {FRAC_BITS{1'b0}}};
      e_nxt.ln[i].big = {{(QW-HW){1'b0}}, nw[NW-1:QB]} >= p_r.den;
      e_nxt.ln[i].rem = {{(QRW-HW){1'b0}}, nw[NW-1:QB]};
      e_nxt.ln[i].lo  = nw[QB-1:0];
      e_nxt.ln[i].q   = '0;
      e_nxt.ln[i].sgn = p_r.ln[i].neg ^ p_r.den_neg;
    end
  end

  // restoring division, one quotient bit per stage per lane
  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic    v_p;
    dstage_t s_p, s_nxt;

    if (k == 0) begin : g_first
      assign v_p = ve_r;
      assign s_p = e_r;
    end else begin : g_next
      assign v_p = vk_r[k-1];
      assign s_p = k_r[k-1];
    end

    assign rdk[k] = !vk_r[k] || rdk[k+1];

    always_comb begin
      logic [QRW-1:0] t;
      logic           ge;
      s_nxt = s_p;
      for (int i = 0; i < 2; i++) begin
        t  = {s_p.ln[i].rem[QW-1:0], s_p.ln[i].lo[QB-1]};
        ge = t >= {1'b0, s_p.den};
        s_nxt.ln[i].rem = ge ? (t - {1'b0, s_p.den}) : t;
        s_nxt.ln[i].lo  = {s_p.ln[i].lo[QB-2:0], 1'b0};
        s_nxt.ln[i].q   = {s_p.ln[i].q[QB-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vk_r[k] <= 1'b0;
      end else if (rdk[k]) begin
        vk_r[k] <= v_p;
      end
    end

    always_ff @(posedge clk) begin
      if (rdk[k]) k_r[k] <= s_nxt;
    end
  end

  // apply sign, saturate, build the result item
  always_comb begin
    logic [1:0]    ovf;
    logic [CW-1:0] val [2];
    logic          neg;
    dlane_t        ln;
    for (int i = 0; i < 2; i++) begin
      ln     = k_r[QB-1].ln[i];
      neg    = ln.sgn && (ln.big || (ln.q != '0));
      ovf[i] = 1'b0;
      if (neg) begin
        if (ln.big || (ln.q > ROOT_MIN)) begin
          ovf[i] = 1'b1;
          val[i] = ROOT_MIN;
        end else begin
          val[i] = ~ln.q + 1'b1;
        end
      end else begin
        if (ln.big || ln.q[QB-1]) begin
          ovf[i] = 1'b1;
          val[i] = ROOT_MAX;
        end else begin
          val[i] = ln.q;
        end
      end
    end
    f_nxt              = '0;
    f_nxt.has_solution = k_r[QB-1].ok;
    if (k_r[QB-1].ok) begin
      f_nxt.root_first  = val[0];
      f_nxt.root_second = val[1];
      f_nxt.overflow    = |ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vp_r <= 1'b0;
      ve_r <= 1'b0;
      vf_r <= 1'b0;
    end else begin
      if (rdy_p) vp_r <= in_valid;
      if (rdy_e) ve_r <= vp_r;
      if (rdy_f) vf_r <= vk_r[QB-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_p) p_r <= p_nxt;
    if (rdy_e) e_r <= e_nxt;
    if (rdy_f) f_r <= f_nxt;
  end

  assign out_valid = vf_r;
  assign out_item  = f_r;

endmodule

// ===== hw/rtl/quadratic_root_solver.sv =====
// Depth: 72 register stages from input accept to result valid (4 front,
// 33 root, 35 divide; the first front stage takes the item at the accepting edge).
// Throughput: one item per cycle while out_ready is high; a stage holds in place only
// while the stage after it is full and stalled, so bubbles are squeezed out behind
// a stall. The 33-stage root and 32-stage two-lane restoring divider set the depth.
// Reset (synchronous, rst_n low): all valid bits clear, epsilon returns to 1.
module quadratic_root_solver #(
  parameter int FRAC_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  qrs_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output qrs_pkg::out_item_t        out_item,
  input  logic                      cfg_wr_en,
  input  logic [qrs_pkg::EPS_W-1:0] cfg_wr_data
);
  import qrs_pkg::*;

  logic [EPS_W-1:0] eps_r;
  logic             fv, fr, sv, sr;
  logic [DW-1:0]    fd;
  meta_t            fm, sm;
  logic [SW-1:0]    sroot;

  // epsilon register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= EPS_W'(1);
    end else if (cfg_wr_en) begin
      eps_r <= cfg_wr_data;
    end
  end

  qrs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk, .rst_n,
    .epsilon   (eps_r),
    .in_valid, .in_ready, .in_item,
    .out_valid (fv),
    .out_ready (fr),
    .out_d     (fd),
    .out_meta  (fm)
  );

  qrs_sqrt u_sqrt (
    .clk, .rst_n,
    .in_valid  (fv),
    .in_ready  (fr),
    .in_d      (fd),
    .in_meta   (fm),
    .out_valid (sv),
    .out_ready (sr),
    .out_root  (sroot),
    .out_meta  (sm)
  );

  qrs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk, .rst_n,
    .in_valid  (sv),
    .in_ready  (sr),
    .in_root   (sroot),
    .in_meta   (sm),
    .out_valid, .out_ready, .out_item
  );

endmodule

// ===== hw/rtl/qrs_checker.sv =====
// Port-level checks for the quadratic root solver, bound to the top level
`include "assert_macros.svh"

module qrs_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input qrs_pkg::out_item_t out_item
);
  import qrs_pkg::*;

  logic roots_zero, first_sat, second_sat, out_stall;

  assign roots_zero = (out_item.root_first == '0) && (out_item.root_second == '0);
  assign first_sat  = (out_item.root_first == ROOT_MAX) || (out_item.root_first == ROOT_MIN);
  assign second_sat = (out_item.root_second == ROOT_MAX) || (out_item.root_second == ROOT_MIN);
  assign out_stall  = out_valid && !out_ready;

  // a stalled result item holds
  `QRS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_item))

  // with the output free, the whole pipe moves and takes an item
  `QRS_ASSERT_IMPL(a_in_free, clk, rst_n, !out_valid || out_ready, in_ready)

  // no solution gives zero roots and no overflow
  `QRS_ASSERT_IMPL(a_none_zero, clk, rst_n, out_valid && !out_item.has_solution, roots_zero && !out_item.overflow)

  // overflow only with a saturated root
  `QRS_ASSERT_IMPL(a_ovf_sat, clk, rst_n, out_valid && out_item.overflow, first_sat || second_sat)

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (.*);

// ===== bench/quadratic_root_solver_test.sv =====
// Self-checking testbench for the fixed-point quadratic root solver
module quadratic_root_solver_test;
  import qrs_pkg::*;

  localparam int LATENCY = 72;
  localparam int N_RANDOM = 1950;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_item;
  logic out_valid;
  logic out_ready;
  out_item_t out_item;
  logic cfg_wr_en;
  logic [EPS_W-1:0] cfg_wr_data;

  quadratic_root_solver dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predictor copy of the threshold register
  logic [EPS_W-1:0] eps_model;

  in_item_t coef_queue[$];
  out_item_t root_queue[$];
  int n_fail;
  int n_checked;
  int n_none, n_lin, n_dbl, n_two, n_ovf;
  bit hold_sender;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // magnitude as 33-bit unsigned, so the most negative word maps to 2^31
  function automatic logic [32:0] abs33(input logic signed [31:0] v);
    logic signed [32:0] w;
    w = v;
    return w[32] ? 33'(-w) : 33'(w);
  endfunction

  function automatic bit is_small(input logic signed [31:0] v, input logic [EPS_W-1:0] e);
    return (v == 0) || (abs33(v) < {17'd0, e});
  endfunction

  // signed quotient mn*2^16/md truncated towards zero, saturated to 32 bits
  function automatic logic [31:0] scaled_div(input logic [65:0] mn, input bit num_neg,
                                             input logic [65:0] md, input bit den_neg,
                                             inout bit ovf);
    logic [127:0] q;
    bit neg;
    q = ({62'd0, mn} << 16) / {62'd0, md};
    neg = (num_neg != den_neg) && (q != 0);
    if (neg) begin
      if (q > 128'h8000_0000) begin
        ovf = 1'b1;
        q = 128'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 128'h7FFF_FFFF) begin
      ovf = 1'b1;
      q = 128'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic logic [32:0] floor_sqrt(input logic [67:0] d);
    logic [32:0] r;
    logic [32:0] t;
    r = '0;
    for (int k = 32; k >= 0; k--) begin
      t = r | (33'd1 << k);
      if ({68'd0, t} * {68'd0, t} <= {68'd0, d}) r = t;
    end
    return r;
  endfunction

  function automatic out_item_t solve_roots(input in_item_t it);
    out_item_t res;
    logic signed [31:0] a, b, c;
    logic [67:0] b2, p4, disc;
    logic [65:0] den;
    logic [32:0] s;
    logic signed [35:0] n0, n1;
    bit ovf;
    a = it.coef_a;
    b = it.coef_b;
    c = it.coef_c;
    ovf = 1'b0;
    res = '0;
    if (is_small(a, eps_model)) begin
      if (!is_small(b, eps_model)) begin
        res.has_solution = 1'b1;
        res.root_first = scaled_div(66'(abs33(c)), c > 0, 66'(abs33(b)), b < 0, ovf);
        res.root_second = res.root_first;
      end
      n_lin += res.has_solution;
      n_none += !res.has_solution;
    end else begin
      b2 = 68'(abs33(b)) * 68'(abs33(b));
      p4 = (68'(abs33(a)) * 68'(abs33(c))) << 2;
      den = 66'(abs33(a)) << 1;
      if ((a < 0) != (c < 0) || b2 >= p4) begin
        disc = ((a < 0) != (c < 0)) ? b2 + p4 : b2 - p4;
        res.has_solution = 1'b1;
        if (disc < (68'(eps_model) << 16)) begin
          n_dbl++;
          res.root_first = scaled_div(66'(abs33(b)), b > 0, den, a < 0, ovf);
          res.root_second = res.root_first;
        end else begin
          n_two++;
          s = floor_sqrt(disc);
          n0 = -36'(b) - 36'(s);
          n1 = -36'(b) + 36'(s);
          res.root_first = scaled_div(66'(n0 < 0 ? -n0 : n0), n0 < 0, den, a < 0, ovf);
          res.root_second = scaled_div(66'(n1 < 0 ? -n1 : n1), n1 < 0, den, a < 0, ovf);
        end
      end else begin
        n_none++;
      end
    end
    res.overflow = ovf;
    n_ovf += ovf;
    return res;
  endfunction

  // driver: bursts of items with random gaps
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_ready) begin
      // holding the offered item
    end else begin
      if (in_valid) begin
        root_queue.push_back(solve_roots(in_item));
      end
      if (gap_left > 0 || hold_sender || coef_queue.size() == 0) begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
      end else begin
        in_valid <= 1'b1;
        in_item <= coef_queue.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 40);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // monitor: receiver stalls in its own on/off pattern
  int stall_phase;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (root_queue.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_item);
          n_fail++;
        end else begin
          out_item_t exp_item;
          exp_item = root_queue.pop_front();
          n_checked++;
          if (out_item.has_solution !== exp_item.has_solution) begin
            $display("%0t: has_solution expected %0b actual %0b", $time,
                     exp_item.has_solution, out_item.has_solution);
            n_fail++;
          end
          if (out_item.root_first !== exp_item.root_first) begin
            $display("%0t: root_first expected %h actual %h", $time,
                     exp_item.root_first, out_item.root_first);
            n_fail++;
          end
          if (out_item.root_second !== exp_item.root_second) begin
            $display("%0t: root_second expected %h actual %h", $time,
                     exp_item.root_second, out_item.root_second);
            n_fail++;
          end
          if (out_item.overflow !== exp_item.overflow) begin
            $display("%0t: overflow expected %0b actual %0b", $time,
                     exp_item.overflow, out_item.overflow);
            n_fail++;
          end
        end
      end
      stall_phase <= (stall_phase + 1) % 64;
      if (stall_phase < 20) out_ready <= 1'b1;
      else if (stall_phase < 28) out_ready <= 1'b0;
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 8000000)) - 4000000);
      2: return 32'($signed($urandom_range(0, 600000)) - 300000);
      3: return 32'($signed($urandom_range(0, 40)) - 20);
      4: return ($urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000) ^ $urandom_range(0, 3);
      default: return 32'($signed($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic add_item(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c);
    in_item_t it;
    it.coef_a = a;
    it.coef_b = b;
    it.coef_c = c;
    coef_queue.push_back(it);
  endtask

  // wait until every item has been sent and every result seen, then drain
  task automatic drain_all();
    while (coef_queue.size() != 0 || in_valid || root_queue.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_eps(input logic [EPS_W-1:0] v);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    eps_model = v;
    @(posedge clk);
  endtask

  task automatic random_phase(input int count);
    int roots_a;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 2) == 0) begin
        // pick integer roots r1, r2 and build a*(x-r1)*(x-r2) in Q16.16
        roots_a = $urandom_range(1, 4);
        begin
          int r1, r2;
          r1 = $signed($urandom_range(0, 200)) - 100;
          r2 = ($urandom_range(0, 3) == 0) ? r1 : $signed($urandom_range(0, 200)) - 100;
          add_item(32'(roots_a << 16), 32'(-roots_a * (r1 + r2)) << 16,
                   32'(roots_a * r1 * r2) << 16);
        end
      end else begin
        add_item(rand_coef(), rand_coef(), rand_coef());
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_item = '0;
    out_ready = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_sender = 1'b0;
    eps_model = 16'd1;
    n_fail = 0;
    n_checked = 0;
    n_none = 0; n_lin = 0; n_dbl = 0; n_two = 0; n_ovf = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed items at reset threshold
    add_item(32'h0001_0000, 32'hFFFD_0000, 32'h0002_0000);   // two roots 1 and 2
    add_item(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);   // double root
    add_item(32'h0001_0000, 32'h0000_0000, 32'h0001_0000);   // negative discriminant
    add_item(32'h0000_0000, 32'h0002_0000, 32'h0004_0000);   // linear
    add_item(32'h0000_0000, 32'h0000_0000, 32'h0004_0000);   // no solution, degenerate
    add_item(32'h0000_0000, 32'h0000_0001, 32'h7FFF_FFFF);   // linear overflow
    add_item(32'h0000_0000, 32'h0000_0001, 32'h8000_0000);
    add_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    add_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    add_item(32'h0000_0001, 32'h7FFF_FFFF, 32'h0000_0000);   // tiny a, huge roots
    add_item(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    add_item(32'h0000_0001, 32'h0000_0000, 32'h0000_0000);
    add_item(32'hFFFF_0000, 32'h0000_0000, 32'h0004_0000);   // negative a
    add_item(32'h0000_0000, 32'h8000_0000, 32'h8000_0000);
    add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    drain_all();

    // epsilon zero: exact zeros still linear
    write_eps(16'd0);
    add_item(32'h0000_0000, 32'h0000_0000, 32'h0000_0005);
    add_item(32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0005);
    add_item(32'h0000_0001, 32'h0000_0002, 32'h0000_0001);   // discriminant zero
    add_item(32'h0001_0000, 32'hFFFE_0000, 32'h0001_0000);
    random_phase(N_RANDOM / 4);
    // part way through, hold the sender until every outstanding result is back
    repeat (200) @(posedge clk);
    hold_sender = 1'b1;
    while (in_valid || root_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    hold_sender = 1'b0;
    drain_all();

    write_eps(16'hFFFF);
    add_item(32'h0000_FFFE, 32'h0000_FFFE, 32'h0001_0000);
    add_item(32'h0000_FFFF, 32'h0001_0000, 32'h0001_0000);
    random_phase(N_RANDOM / 4);
    drain_all();

    write_eps(16'd1);
    random_phase(N_RANDOM / 4);
    drain_all();

    write_eps(16'($urandom_range(2, 4000)));
    random_phase(N_RANDOM / 4);
    drain_all();

    $display("Checked %0d results over several threshold settings including 0 and 65535.",
             n_checked);
    $display("Cases: %0d none, %0d linear, %0d double, %0d two-root, %0d saturated.",
             n_none, n_lin, n_dbl, n_two, n_ovf);
    if (n_fail == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("FAILURE");
    $finish;
  end

endmodule

// ===== quadratic_root_solver.f =====
+incdir+hw/rtl
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_front.sv
hw/rtl/qrs_sqrt.sv
hw/rtl/qrs_div.sv
hw/rtl/quadratic_root_solver.sv
hw/rtl/qrs_checker.sv
bench/quadratic_root_solver_test.sv
